@@ rtl/i2c_adc_dac_transaction_master_unit_assert.svh @@
// ----------------------------------------------------------------------------
// I2C converter master assertion macros
// Shared concurrent-assertion shorthands, clocked on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_ADC_DAC_TRANSACTION_MASTER_UNIT_ASSERT_SVH
`define I2C_ADC_DAC_TRANSACTION_MASTER_UNIT_ASSERT_SVH

// same-cycle implication
`define I2CADC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cadc: same-cycle check failed");

// next-cycle implication
`define I2CADC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cadc: next-cycle check failed");

`endif

@@ rtl/i2cadc_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C converter master package
// Transaction types, segment codes and the fixed segment and byte tables.
// ----------------------------------------------------------------------------
package i2cadc_pkg;

	typedef struct packed {
		logic [1:0] opcode;
		logic [1:0] channel;
		logic [7:0] dac_value;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       ack_seen;
		logic       read_valid;
		logic [7:0] read_byte;
	} res_t;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ADC  = 2'd1;
	localparam logic [1:0] OP_DAC  = 2'd2;

	localparam logic [2:0] K_NONE    = 3'd0;
	localparam logic [2:0] K_START   = 3'd1;
	localparam logic [2:0] K_RESTART = 3'd2;
	localparam logic [2:0] K_BYTE    = 3'd3;
	localparam logic [2:0] K_ACK     = 3'd4;
	localparam logic [2:0] K_READ    = 3'd5;
	localparam logic [2:0] K_NOACK   = 3'd6;
	localparam logic [2:0] K_STOP    = 3'd7;

	localparam logic [4:0] SEG_IDLE      = 5'd0;
	localparam logic [4:0] SEG_ADC_FIRST = 5'd1;
	localparam logic [4:0] SEG_ADC_ADDR  = 5'd2;
	localparam logic [4:0] SEG_ADC_CTRL  = 5'd4;
	localparam logic [4:0] SEG_ADC_RADDR = 5'd7;
	localparam logic [4:0] SEG_ADC_LAST  = 5'd11;
	localparam logic [4:0] SEG_DAC_FIRST = 5'd12;
	localparam logic [4:0] SEG_DAC_ADDR  = 5'd13;
	localparam logic [4:0] SEG_DAC_CTRL  = 5'd15;
	localparam logic [4:0] SEG_DAC_DATA  = 5'd17;
	localparam logic [4:0] SEG_DAC_LAST  = 5'd19;

	localparam logic [7:0] ADDR_WRITE = 8'h90;
	localparam logic [7:0] CTRL_BYTE  = 8'h40;
	localparam logic [7:0] ADDR_READ  = 8'h91;

	localparam logic [1:0] PH_LOW  = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LAST = 2'd2;

	function automatic logic [2:0] seg_kind(input logic [4:0] seg);
		logic [2:0] k;
		case (seg)
			5'd1, 5'd12:                           k = K_START;
			5'd2, 5'd4, 5'd7, 5'd13, 5'd15, 5'd17: k = K_BYTE;
			5'd3, 5'd5, 5'd8, 5'd14, 5'd16, 5'd18: k = K_ACK;
			5'd6:                                  k = K_RESTART;
			5'd9:                                  k = K_READ;
			5'd10:                                 k = K_NOACK;
			5'd11, 5'd19:                          k = K_STOP;
			default:                               k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] byte_for(input logic [4:0] seg, input logic [1:0] chan,
		input logic [7:0] value);
		logic [7:0] b;
		case (seg)
			SEG_ADC_ADDR, SEG_DAC_ADDR: b = ADDR_WRITE;
			SEG_ADC_CTRL:               b = CTRL_BYTE | {6'd0, chan};
			SEG_DAC_CTRL:               b = CTRL_BYTE;
			SEG_ADC_RADDR:              b = ADDR_READ;
			SEG_DAC_DATA:               b = value;
			default:                    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/i2c_adc_dac_transaction_master_unit.sv @@
// ----------------------------------------------------------------------------
// I2C converter transaction master, top level
// Tick-driven master for ADC read and DAC write on an 8-bit I2C converter.
// ----------------------------------------------------------------------------
// Use:
//   cmd channel (cmd_valid/cmd_ready, cmd): one transaction per bus tick, with
//   the opcode (tick, ADC read, DAC write), channel, DAC byte and sampled SDA.
//   res channel (res_valid/res_ready, res): one transaction per tick, giving
//   SCL and SDA drive levels, busy, last acknowledge, read strobe and byte.
//   Start opcodes are taken only when the sequencer is idle; otherwise the
//   tick just advances the running sequence. Each bit costs three ticks.
// Path: a command accepted into the input register is stepped by the
//   combinational logic and taken into the result register, which drives res.
// Throughput: one tick per clock while res is not held off; the step is one
//   pass of combinational logic between the input and result registers.
// Reset: arst_n clears the sequencer to idle, both stages empty, ack and
//   received byte to zero.
// Stall: while res is held off, the result register keeps its transaction
//   and one more command waits in the input register; cmd_ready then drops.
// ----------------------------------------------------------------------------
module i2c_adc_dac_transaction_master_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  i2cadc_pkg::cmd_t  cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output i2cadc_pkg::res_t  res
);
	import i2cadc_pkg::*;

	cmd_t cmd_s1;
	logic valid_s1;
	res_t step_res;
	res_t res_q;
	logic res_valid_q;
	logic adv;

	// step whenever a tick is waiting and the result slot is free or draining
	assign adv       = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	i2cadc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd    (cmd_s1),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ rtl/i2cadc_seq.sv @@
// ----------------------------------------------------------------------------
// I2C converter master sequencer
// Segment state and the one-tick step: pin levels, shifts and segment advance.
// ----------------------------------------------------------------------------
module i2cadc_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  i2cadc_pkg::cmd_t   cmd,
	output i2cadc_pkg::res_t   res
);
	import i2cadc_pkg::*;

	logic [4:0] seq_q, seq_n;
	logic [3:0] bit_q, bit_n, bit_inc;
	logic [1:0] phase_q, phase_n;
	logic [7:0] tx_q, tx_n, rx_q, rx_n, val_q, val_n;
	logic [1:0] op_q, op_n, ch_q, ch_n;
	logic       ack_q, ack_n;
	logic [2:0] kind;
	logic [1:0] ph;
	logic       scl, sda, busy, rvalid, seg_done;

	always_comb begin
		seq_n = seq_q; bit_n = bit_q; phase_n = phase_q;
		tx_n = tx_q; rx_n = rx_q; val_n = val_q;
		op_n = op_q; ch_n = ch_q; ack_n = ack_q;
		scl = 1'b1; sda = 1'b1; busy = 1'b0; rvalid = 1'b0; seg_done = 1'b0;
		bit_inc = bit_q + 4'd1;

		// starts only from idle; the accepting tick already drives START
		if (seq_q == SEG_IDLE) begin
			if (cmd.opcode == OP_ADC) begin
				op_n = OP_ADC; ch_n = cmd.channel;
				seq_n = SEG_ADC_FIRST; phase_n = PH_LOW; bit_n = 4'd0;
			end else if (cmd.opcode == OP_DAC) begin
				op_n = OP_DAC; val_n = cmd.dac_value;
				seq_n = SEG_DAC_FIRST; phase_n = PH_LOW; bit_n = 4'd0;
			end
		end

		kind = seg_kind(seq_n);
		ph   = phase_n;
		if (kind == K_NONE) begin
			seq_n = SEG_IDLE; phase_n = PH_LOW; bit_n = 4'd0;
		end else begin
			busy = 1'b1;
			case (kind)
				K_START: begin
					scl = (ph != PH_LAST); sda = (ph == PH_LOW);
				end
				K_RESTART: begin
					scl = (ph != PH_LOW); sda = (ph != PH_LAST);
				end
				K_BYTE: begin
					scl = (ph == PH_HIGH); sda = tx_q[7];
					if (ph == PH_LAST) tx_n = {tx_q[6:0], 1'b0};
				end
				K_ACK: begin
					scl = (ph == PH_HIGH);
					if (ph == PH_HIGH) ack_n = ~cmd.sda_in;
				end
				K_READ: begin
					scl = (ph == PH_HIGH);
					if (ph == PH_HIGH) rx_n = {rx_q[6:0], cmd.sda_in};
				end
				K_NOACK: begin
					scl = (ph == PH_HIGH);
				end
				default: begin // stop
					scl = (ph != PH_LOW); sda = (ph == PH_LAST);
				end
			endcase

			if (ph >= PH_LAST) begin
				phase_n = PH_LOW;
				if (kind == K_BYTE || kind == K_READ) begin
					bit_inc = bit_n + 4'd1;
					if (bit_inc[3]) begin
						bit_n = 4'd0; seg_done = 1'b1;
					end else begin
						bit_n = bit_inc;
					end
				end else begin
					seg_done = 1'b1;
				end
			end else begin
				phase_n = ph + 2'd1;
			end

			if (seg_done) begin
				if (seq_n == SEG_ADC_LAST || seq_n == SEG_DAC_LAST) begin
					rvalid = (seq_n == SEG_ADC_LAST);
					seq_n  = SEG_IDLE;
				end else begin
					seq_n = seq_n + 5'd1;
					if (seg_kind(seq_n) == K_BYTE) tx_n = byte_for(seq_n, ch_n, val_n);
				end
			end
		end

		res.scl_level   = scl;
		res.sda_release = sda;
		res.busy_res    = busy;
		res.ack_seen    = ack_n;
		res.read_valid  = rvalid;
		res.read_byte   = rx_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEG_IDLE; bit_q <= 4'd0; phase_q <= PH_LOW;
			tx_q <= 8'd0; rx_q <= 8'd0; val_q <= 8'd0;
			op_q <= OP_TICK; ch_q <= 2'd0; ack_q <= 1'b0;
		end else if (adv) begin
			seq_q <= seq_n; bit_q <= bit_n; phase_q <= phase_n;
			tx_q <= tx_n; rx_q <= rx_n; val_q <= val_n;
			op_q <= op_n; ch_q <= ch_n; ack_q <= ack_n;
		end
	end

endmodule

@@ rtl/i2cadc_chk.sv @@
// ----------------------------------------------------------------------------
// I2C converter master port checker
// Port-level checks on both channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_adc_dac_transaction_master_unit_assert.svh"

module i2cadc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input i2cadc_pkg::cmd_t  cmd,
	input logic              res_valid,
	input logic              res_ready,
	input i2cadc_pkg::res_t  res
);
	import i2cadc_pkg::*;

	// a refused command holds
	`I2CADC_ASSERT_NXT(a_cmd_hold, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd))
	// a stalled result holds
	`I2CADC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
	// idle ticks leave the bus released
	`I2CADC_ASSERT_IMP(a_idle_bus, res_valid && !res.busy_res, res.scl_level && res.sda_release)
	// read strobe only on the last STOP tick of a running transaction
	`I2CADC_ASSERT_IMP(a_read_stop, res_valid && res.read_valid,
		res.busy_res && res.scl_level && res.sda_release)
	// with the result slot empty the input side is never refused
	`I2CADC_ASSERT_IMP(a_ready_free, !res_valid, cmd_ready)

endmodule

bind i2c_adc_dac_transaction_master_unit i2cadc_chk u_i2cadc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
